/* rtl/alfl_pkg.sv */
// Shared types, codes and sizes for the linked list block.
package alfl_pkg;

	localparam int NODE_COUNT = 64;
	localparam int IDX_W      = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int CNT_W      = $clog2(NODE_COUNT + 1);
	localparam int COUNT_W    = 7;
	localparam int OP_W       = 3;

	typedef logic signed [31:0] word_t;

	localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_DELETE    = 3'd2;
	localparam logic [OP_W-1:0] OP_SEARCH    = 3'd3;
	localparam logic [OP_W-1:0] OP_READ      = 3'd4;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_PUT,
		CELL_ROTATE,
		CELL_DROP
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [CNT_W-1:0] len;
		word_t            data;
	} cell_ctl_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		word_t           value;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic               found;
		word_t              item_value;
		logic [COUNT_W-1:0] count;
		logic               last;
	} rsp_t;

endpackage

/* rtl/array_linked_list_with_free_list.sv */
// Top level: ordered row of value slots with a walk controller and response register.
//
//   channel | valid     | stall     | payload
//   request | req_valid | req_stall | req_data (op, value)
//   result  | rsp_valid | rsp_stall | rsp_data (status, found, item_value, count, last)
//
// Inserts, unused ops and requests on an empty list are answered from the response register without a walk.
// Delete, search and read out rotate the occupied slots past slot 0, one slot
// per cycle while the result is not stalled, visiting each value the list holds (up to 64).
// Read out gives one result beat per cycle; a stalled result holds the walk.
// After reset the list is empty; slot contents are only read once written.
module array_linked_list_with_free_list import alfl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req_data,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp_data
);

	typedef enum logic {
		S_IDLE,
		S_WALK
	} state_t;

	typedef enum logic [1:0] {
		M_DEL,
		M_SRCH,
		M_READ
	} mode_t;

	state_t           state_q;
	mode_t            mode_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] len_q;
	logic [CNT_W-1:0] step_q;
	logic             hit_q;
	word_t            target_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	cell_ctl_t        ctl;
	word_t            vals [NODE_COUNT];
	word_t            head;
	logic             match;
	logic             rsp_free;
	logic             accept;
	logic             walk_go;
	logic             final_step;
	logic             full;
	logic [CNT_W-1:0] cnt_inc;
	logic [CNT_W-1:0] cnt_dec;

	for (genvar i = 0; i < NODE_COUNT; i++) begin : g_cell
		word_t lv;
		word_t rv;
		if (i == 0) begin : g_first
			assign lv = ctl.data;
		end else begin : g_mid_l
			assign lv = vals[i-1];
		end
		if (i == NODE_COUNT - 1) begin : g_last
			assign rv = ctl.data;
		end else begin : g_mid_r
			assign rv = vals[i+1];
		end
		alfl_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.idx       (IDX_W'(i)),
			.left_val  (lv),
			.right_val (rv),
			.val_q     (vals[i])
		);
	end

	always_comb begin
		head       = vals[0];
		match      = (head == target_q);
		rsp_free   = !rsp_valid_q || !rsp_stall;
		req_stall  = (state_q != S_IDLE) || !rsp_free;
		accept     = req_valid && !req_stall;
		walk_go    = (state_q == S_WALK) && rsp_free;
		final_step = (step_q == count_q - CNT_W'(1));
		full       = (count_q == CNT_W'(NODE_COUNT));
		cnt_inc    = count_q + CNT_W'(1);
		cnt_dec    = count_q - CNT_W'(1);

		ctl.op   = CELL_HOLD;
		ctl.len  = count_q;
		ctl.data = req_data.value;
		if (accept && !full) begin
			if (req_data.op == OP_INS_FRONT) ctl.op = CELL_PUSH;
			else if (req_data.op == OP_INS_BACK) ctl.op = CELL_PUT;
		end
		if (walk_go) begin
			ctl.data = head;
			ctl.len  = len_q;
			// unlink the first match, rotate everything else
			if (mode_q == M_DEL && !hit_q && match) ctl.op = CELL_DROP;
			else ctl.op = CELL_ROTATE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= M_SRCH;
			count_q     <= '0;
			len_q       <= '0;
			step_q      <= '0;
			hit_q       <= 1'b0;
			target_q    <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall) rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						target_q <= req_data.value;
						len_q    <= count_q;
						step_q   <= '0;
						hit_q    <= 1'b0;
						case (req_data.op)
							OP_INS_FRONT, OP_INS_BACK: begin
								rsp_valid_q <= 1'b1;
								if (full) begin
									rsp_q <= '{status: ST_FULL, found: 1'b0, item_value: '0,
										count: COUNT_W'(count_q), last: 1'b1};
								end else begin
									count_q <= cnt_inc;
									rsp_q   <= '{status: ST_OK, found: 1'b0, item_value: '0,
										count: COUNT_W'(cnt_inc), last: 1'b1};
								end
							end
							OP_DELETE: begin
								if (count_q == '0) begin
									rsp_valid_q <= 1'b1;
									rsp_q <= '{status: ST_EMPTY, found: 1'b0, item_value: '0,
										count: COUNT_W'(count_q), last: 1'b1};
								end else begin
									mode_q  <= M_DEL;
									state_q <= S_WALK;
								end
							end
							OP_SEARCH: begin
								if (count_q == '0) begin
									rsp_valid_q <= 1'b1;
									rsp_q <= '{status: ST_OK, found: 1'b0, item_value: '0,
										count: COUNT_W'(count_q), last: 1'b1};
								end else begin
									mode_q  <= M_SRCH;
									state_q <= S_WALK;
								end
							end
							OP_READ: begin
								if (count_q == '0) begin
									rsp_valid_q <= 1'b1;
									rsp_q <= '{status: ST_EMPTY, found: 1'b0, item_value: '0,
										count: COUNT_W'(count_q), last: 1'b1};
								end else begin
									mode_q  <= M_READ;
									state_q <= S_WALK;
								end
							end
							default: begin
								rsp_valid_q <= 1'b1;
								rsp_q <= '{status: ST_OK, found: 1'b0, item_value: '0,
									count: COUNT_W'(count_q), last: 1'b1};
							end
						endcase
					end
				end
				S_WALK: begin
					if (rsp_free) begin
						step_q <= step_q + CNT_W'(1);
						hit_q  <= hit_q | match;
						if (ctl.op == CELL_DROP) len_q <= len_q - CNT_W'(1);
						if (mode_q == M_READ) begin
							rsp_valid_q <= 1'b1;
							rsp_q <= '{status: ST_OK, found: 1'b0, item_value: head,
								count: COUNT_W'(count_q), last: final_step};
						end
						if (final_step) begin
							state_q <= S_IDLE;
							if (mode_q == M_SRCH) begin
								rsp_valid_q <= 1'b1;
								rsp_q <= '{status: ST_OK, found: hit_q | match, item_value: '0,
									count: COUNT_W'(count_q), last: 1'b1};
							end else if (mode_q == M_DEL) begin
								rsp_valid_q <= 1'b1;
								if (hit_q || match) begin
									count_q <= cnt_dec;
									rsp_q <= '{status: ST_OK, found: 1'b0, item_value: '0,
										count: COUNT_W'(cnt_dec), last: 1'b1};
								end else begin
									rsp_q <= '{status: ST_NOT_FOUND, found: 1'b0,
										item_value: '0, count: COUNT_W'(count_q), last: 1'b1};
								end
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

`ifndef SYNTHESIS
	a_walk_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> (len_q == count_q || len_q == cnt_dec))
		else $error("ring length drifted from list count during walk");

	a_walk_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> (count_q != '0 && step_q < count_q))
		else $error("walk step out of range");

	a_drop_once: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op == CELL_DROP |=> hit_q)
		else $error("drop not recorded as hit");
`endif

endmodule

/* rtl/alfl_cell.sv */
// One list slot: holds one value and trades it with its neighbors.
module alfl_cell import alfl_pkg::*; (
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  logic [IDX_W-1:0] idx,
	input  word_t            left_val,
	input  word_t            right_val,
	output word_t            val_q
);

	logic [CNT_W-1:0] pos;
	logic [CNT_W-1:0] tail;
	word_t            val_nxt;

	always_comb begin
		pos     = CNT_W'(idx);
		tail    = ctl.len - CNT_W'(1);
		val_nxt = val_q;
		unique case (ctl.op)
			CELL_HOLD: ;
			CELL_PUSH: val_nxt = left_val;
			CELL_PUT: begin
				if (pos == ctl.len) val_nxt = ctl.data;
			end
			CELL_ROTATE: begin
				// tail slot takes the head value back
				if (pos < tail) val_nxt = right_val;
				else if (pos == tail) val_nxt = ctl.data;
			end
			CELL_DROP: begin
				if (pos < tail) val_nxt = right_val;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= val_nxt;
	end

endmodule
